### src/wmpd_pkg.sv
// Shared types and constants of the wake-on-LAN magic packet detector.
package wmpd_pkg;

  localparam int POS_W  = 11;
  localparam int IHB_W  = 6;
  localparam int MAC_W  = 48;
  localparam int CODE_W = 4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] FRAG_MASK      = 16'h3fff;
  localparam logic [7:0]  SYNC_BYTE      = 8'hff;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] WAKE_UDP_LEN   = 16'd110;
  localparam logic [4:0]  MAC_COPIES     = 5'd16;
  localparam logic [2:0]  MAC_BYTES      = 3'd6;

  localparam logic [POS_W-1:0] POS_ETHERTYPE = 11'd13;
  localparam logic [POS_W-1:0] POS_VER_IHL   = 11'd14;
  localparam logic [POS_W-1:0] POS_FRAG      = 11'd21;
  localparam logic [POS_W-1:0] POS_PROTO     = 11'd23;
  localparam logic [POS_W-1:0] ETH_HDR_BYTES = 11'd14;

  localparam logic [CODE_W-1:0] RSN_FORWARD   = 4'd0;
  localparam logic [CODE_W-1:0] RSN_ETHERTYPE = 4'd1;
  localparam logic [CODE_W-1:0] RSN_VERSION   = 4'd2;
  localparam logic [CODE_W-1:0] RSN_FRAGMENT  = 4'd3;
  localparam logic [CODE_W-1:0] RSN_PROTOCOL  = 4'd4;
  localparam logic [CODE_W-1:0] RSN_PORT      = 4'd5;
  localparam logic [CODE_W-1:0] RSN_SIZE      = 4'd6;
  localparam logic [CODE_W-1:0] RSN_SYNC      = 4'd7;
  localparam logic [CODE_W-1:0] RSN_COPY      = 4'd8;
  localparam logic [CODE_W-1:0] RSN_TRUNC     = 4'd9;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } stg_t;

  typedef struct packed {
    logic [CODE_W-1:0] reason;
    logic [MAC_W-1:0]  mac;
  } result_t;

  function automatic logic [CODE_W-1:0] merge_fail(input logic [CODE_W-1:0] cur,
                                                    input logic [CODE_W-1:0] code);
    merge_fail = (cur == RSN_FORWARD || code < cur) ? code : cur;
  endfunction

endpackage

### src/wmpd_in_stage.sv
// Input register stage of the detector.
module wmpd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          out_free,
  output wmpd_pkg::stg_t stg,
  output logic          stg_go
);
  import wmpd_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       take;

  assign stg_go    = vld_r && (!last_r || out_free);
  assign in_tready = !vld_r || stg_go;
  assign take      = in_tvalid && in_tready;
  assign vld_nxt   = take ? 1'b1 : (stg_go ? 1'b0 : vld_r);

  assign stg.vld  = vld_r;
  assign stg.data = data_r;
  assign stg.last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

endmodule

### src/wmpd_check.sv
// Per-frame state and header/payload checks of the detector.
module wmpd_check #(
  parameter int MAX_FRAME_BYTES = 1514
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  wmpd_pkg::stg_t    stg,
  input  logic              stg_go,
  output wmpd_pkg::result_t res
);
  import wmpd_pkg::*;

  logic [15:0]       port_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [IHB_W-1:0]  ihb_r, ihb_nxt;
  logic [15:0]       fs_r, fs_nxt;
  logic [CODE_W-1:0] drop_r, drop_nxt;
  logic [MAC_W-1:0]  fc_r, fc_nxt;
  logic [2:0]        cbi_r, cbi_nxt;
  logic [4:0]        cn_r, cn_nxt;

  logic [15:0]       fs_new;
  logic [POS_W-1:0]  udp_start, pay_start;
  logic [7:0]        want;
  logic              take;

  assign take      = pos_r < POS_W'(MAX_FRAME_BYTES);
  assign fs_new    = {fs_r[7:0], stg.data};
  assign udp_start = ETH_HDR_BYTES + POS_W'(ihb_r);
  assign pay_start = udp_start + 11'd8;

  always_comb begin
    case (cbi_r)
      3'd0:    want = fc_r[47:40];
      3'd1:    want = fc_r[39:32];
      3'd2:    want = fc_r[31:24];
      3'd3:    want = fc_r[23:16];
      3'd4:    want = fc_r[15:8];
      3'd5:    want = fc_r[7:0];
      default: want = 8'h00;
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    ihb_nxt  = ihb_r;
    fs_nxt   = fs_r;
    drop_nxt = drop_r;
    fc_nxt   = fc_r;
    cbi_nxt  = cbi_r;
    cn_nxt   = cn_r;
    if (take) begin
      pos_nxt = pos_r + 11'd1;
      fs_nxt  = fs_new;
      if (pos_r == POS_ETHERTYPE && fs_new != ETHERTYPE_IPV4) begin
        drop_nxt = merge_fail(drop_nxt, RSN_ETHERTYPE);
      end
      if (pos_r == POS_VER_IHL) begin
        if (stg.data[7:4] != 4'd4) begin
          drop_nxt = merge_fail(drop_nxt, RSN_VERSION);
        end
        ihb_nxt = {stg.data[3:0], 2'b00};
      end
      if (pos_r == POS_FRAG && (fs_new & FRAG_MASK) != 16'h0000) begin
        drop_nxt = merge_fail(drop_nxt, RSN_FRAGMENT);
      end
      if (pos_r == POS_PROTO && stg.data != PROTO_UDP) begin
        drop_nxt = merge_fail(drop_nxt, RSN_PROTOCOL);
      end
      if (pos_r > POS_VER_IHL) begin
        if (pos_r == udp_start + 11'd3 && fs_new != port_r) begin
          drop_nxt = merge_fail(drop_nxt, RSN_PORT);
        end
        if (pos_r == udp_start + 11'd5 && fs_new != WAKE_UDP_LEN) begin
          drop_nxt = merge_fail(drop_nxt, RSN_SIZE);
        end
        if (pos_r >= pay_start && pos_r < pay_start + 11'd6) begin
          if (stg.data != SYNC_BYTE) begin
            drop_nxt = merge_fail(drop_nxt, RSN_SYNC);
          end
        end else if (pos_r >= pay_start + 11'd6 && cn_r < MAC_COPIES) begin
          if (cn_r == 5'd0) begin
            fc_nxt = {fc_r[39:0], stg.data};
          end else if (want != stg.data) begin
            drop_nxt = merge_fail(drop_nxt, RSN_COPY);
          end
          if (cbi_r + 3'd1 >= MAC_BYTES) begin
            cbi_nxt = 3'd0;
            cn_nxt  = cn_r + 5'd1;
          end else begin
            cbi_nxt = cbi_r + 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    if (drop_nxt != RSN_FORWARD) begin
      res.reason = drop_nxt;
    end else if (cn_nxt < MAC_COPIES) begin
      res.reason = RSN_TRUNC;
    end else begin
      res.reason = RSN_FORWARD;
    end
    res.mac = (res.reason == RSN_FORWARD) ? fc_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= 16'd9;
    end else if (cfg_wr_en) begin
      port_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ihb_r  <= '0;
      fs_r   <= '0;
      drop_r <= '0;
      fc_r   <= '0;
      cbi_r  <= '0;
      cn_r   <= '0;
    end else if (stg_go) begin
      if (stg.last) begin
        pos_r  <= '0;
        ihb_r  <= '0;
        fs_r   <= '0;
        drop_r <= '0;
        fc_r   <= '0;
        cbi_r  <= '0;
        cn_r   <= '0;
      end else begin
        pos_r  <= pos_nxt;
        ihb_r  <= ihb_nxt;
        fs_r   <= fs_nxt;
        drop_r <= drop_nxt;
        fc_r   <= fc_nxt;
        cbi_r  <= cbi_nxt;
        cn_r   <= cn_nxt;
      end
    end
  end

endmodule

### src/wmpd_out_reg.sv
// Result register of the detector.
module wmpd_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  wmpd_pkg::result_t             res,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wmpd_pkg::MAC_W-1:0]    out_tdata,
  output logic [wmpd_pkg::CODE_W-1:0]   out_tuser
);
  import wmpd_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign vld_nxt    = load ? 1'b1 : (out_tready ? 1'b0 : vld_r);
  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.mac;
  assign out_tuser  = res_r.reason;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### src/wol_magic_packet_detector_unit.sv
// Top level of the wake-on-LAN magic packet detector.
//  channel | direction | tdata                 | tuser           | tlast
//  in_     | slave     | [7:0] frame_byte      | -               | last_byte
//  out_    | master    | [47:0] target_mac     | [3:0] reason    | -
//  cfg_    | write     | [15:0] udp_port       | -               | -
// One byte is taken per cycle unless a last byte waits; a byte passes the
// input register and the check logic into the result register.
// Only a frame's last byte waits for a free result register; other bytes
// flow on regardless of out_tready. Synchronous reset clears all control
// state and sets udp_port to 9.
module wol_magic_packet_detector_unit #(
  parameter int MAX_FRAME_BYTES = 1514
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] target_mac
  output logic [3:0]  out_tuser,  // [3:0] reason_code
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import wmpd_pkg::*;

  stg_t    stg;
  logic    stg_go;
  result_t res;

  wmpd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_free  (!out_tvalid || out_tready),
    .stg       (stg),
    .stg_go    (stg_go)
  );

  wmpd_check #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stg         (stg),
    .stg_go      (stg_go),
    .res         (res)
  );

  wmpd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (stg_go && stg.last),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_mac_zero_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != RSN_FORWARD |-> out_tdata == '0)
    else $error("target_mac nonzero on dropped frame");

  a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= RSN_TRUNC)
    else $error("reason code out of range");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    stg.vld && stg.last && out_tvalid && !out_tready |-> !stg_go)
    else $error("last byte advanced into a full result register");

endmodule

### tb/sv/wol_magic_packet_detector_unit_tb.sv
// Self-checking testbench for the wake-on-LAN magic packet detector unit.
`timescale 1ns / 1ps

module wol_magic_packet_detector_unit_tb;
  import wmpd_pkg::*;

  localparam int MAX_FRAME = 200;
  localparam int IP_VERSION = 4;
  localparam int DIR_ROWS = 20;

  typedef enum logic [3:0] {
    FR_GOOD, FR_ETHERTYPE, FR_VERSION, FR_FRAG, FR_PROTO, FR_PORT,
    FR_SIZE, FR_SYNC, FR_COPY, FR_TRUNC, FR_MULTI, FR_NOISE
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t       kind;
    logic [3:0]        ihl;
    logic [MAC_W-1:0]  mac;
    logic [10:0]       pad;
    logic              fixed;
    logic [CODE_W-1:0] reason;
  } frame_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic    fixed;
    result_t want;
  } frame_note_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  byte_item_t  byte_q[$];
  frame_note_t note_q[$];
  result_t     verdict_q[$];
  byte_item_t  next_item;
  result_t     seen;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          fails = 0;

  // detector state
  logic [15:0]       wake_port = 16'd9;
  int                pos_cnt = 0;
  logic [IHB_W-1:0]  hdr_len = '0;
  logic [15:0]       last_two = '0;
  logic [CODE_W-1:0] worst_code = RSN_FORWARD;
  logic [MAC_W-1:0]  cap_mac = '0;
  logic [2:0]        mac_idx = '0;
  logic [4:0]        copies_done = '0;

  wol_magic_packet_detector_unit #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("wol_magic_packet_detector_unit_tb: errors");
    $finish;
  end

  function automatic void note_fail(input logic [CODE_W-1:0] code);
    if (worst_code == RSN_FORWARD || code < worst_code) worst_code = code;
  endfunction

  task automatic scan_frame_byte(input logic [7:0] b, input logic last);
    int p, udp_at, pay_at, sh;
    result_t got;
    frame_note_t note;
    if (pos_cnt < MAX_FRAME) begin
      p = pos_cnt;
      last_two = {last_two[7:0], b};
      if (p == POS_ETHERTYPE && last_two != ETHERTYPE_IPV4) note_fail(RSN_ETHERTYPE);
      if (p == POS_VER_IHL) begin
        if (b[7:4] != IP_VERSION) note_fail(RSN_VERSION);
        hdr_len = {b[3:0], 2'b00};
      end
      if (p == POS_FRAG && (last_two & FRAG_MASK) != 0) note_fail(RSN_FRAGMENT);
      if (p == POS_PROTO && b != PROTO_UDP) note_fail(RSN_PROTOCOL);
      if (p > POS_VER_IHL) begin
        udp_at = ETH_HDR_BYTES + hdr_len;
        if (p == udp_at + 3 && last_two != wake_port) note_fail(RSN_PORT);
        if (p == udp_at + 5 && last_two != WAKE_UDP_LEN) note_fail(RSN_SIZE);
        pay_at = udp_at + 8;
        if (p >= pay_at && p < pay_at + 6) begin
          if (b != SYNC_BYTE) note_fail(RSN_SYNC);
        end else if (p >= pay_at + 6 && copies_done < MAC_COPIES) begin
          if (copies_done == 0) begin
            cap_mac = {cap_mac[39:0], b};
          end else begin
            sh = 40 - 8 * mac_idx;
            if (cap_mac[sh +: 8] != b) note_fail(RSN_COPY);
          end
          mac_idx++;
          if (mac_idx >= MAC_BYTES) begin
            mac_idx = '0;
            copies_done++;
          end
        end
      end
      pos_cnt++;
    end
    if (last) begin
      if (worst_code != RSN_FORWARD) got.reason = worst_code;
      else if (copies_done < MAC_COPIES) got.reason = RSN_TRUNC;
      else got.reason = RSN_FORWARD;
      got.mac = (got.reason == RSN_FORWARD) ? cap_mac : '0;
      note = note_q.pop_front();
      verdict_q.push_back(note.fixed ? note.want : got);
      pos_cnt = 0;
      hdr_len = '0;
      last_two = '0;
      worst_code = RSN_FORWARD;
      cap_mac = '0;
      mac_idx = '0;
      copies_done = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) scan_frame_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          next_item = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.data;
          in_tlast  <= next_item.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: reason_code %0d", out_tuser);
          fails++;
        end else begin
          seen = verdict_q.pop_front();
          if (out_tuser !== seen.reason) begin
            $error("reason_code: expected %0d, got %0d", seen.reason, out_tuser);
            fails++;
          end
          if (out_tdata !== seen.mac) begin
            $error("target_mac: expected %h, got %h", seen.mac, out_tdata);
            fails++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_frame(input frame_kind_t kind, input int ihl, input logic [47:0] mac,
                             input int pad, input logic fixed, input logic [3:0] reason);
    logic [7:0] fb[$];
    int udp_at, full, len, k, n;
    logic [15:0] w;
    frame_note_t note;
    byte_item_t it;
    if (kind == FR_NOISE) begin
      for (k = 0; k < pad; k++) fb.push_back(8'($urandom_range(255)));
      len = pad;
    end else begin
      udp_at = 14 + 4 * ihl;
      full = udp_at + 110;
      for (k = 0; k < full + pad; k++) fb.push_back(8'($urandom_range(255)));
      len = full + pad;
      w = wake_port;
      if (kind == FR_PORT || kind == FR_MULTI) w = w ^ 16'($urandom_range(65535, 1));
      fb[udp_at + 2] = w[15:8];
      fb[udp_at + 3] = w[7:0];
      w = WAKE_UDP_LEN;
      if (kind == FR_SIZE || kind == FR_MULTI) w = w ^ 16'($urandom_range(65535, 1));
      fb[udp_at + 4] = w[15:8];
      fb[udp_at + 5] = w[7:0];
      for (k = 0; k < 6; k++) fb[udp_at + 8 + k] = SYNC_BYTE;
      if (kind == FR_SYNC) fb[udp_at + 8 + $urandom_range(5)] = 8'($urandom_range(254));
      for (k = 0; k < 96; k++) fb[udp_at + 14 + k] = mac[8 * (5 - k % 6) +: 8];
      if (kind == FR_COPY) begin
        k = udp_at + 14 + $urandom_range(95, 6);
        fb[k] = fb[k] ^ 8'($urandom_range(255, 1));
      end
      // IP fields go last so that they win over an overlapping UDP header
      w = ETHERTYPE_IPV4;
      if (kind == FR_ETHERTYPE || kind == FR_MULTI) w = w ^ 16'($urandom_range(65535, 1));
      fb[12] = w[15:8];
      fb[13] = w[7:0];
      n = IP_VERSION;
      if (kind == FR_VERSION) begin
        n = $urandom_range(14);
        if (n >= IP_VERSION) n++;
      end
      fb[14] = {n[3:0], ihl[3:0]};
      w = 16'($urandom_range(3) << 14);
      if (kind == FR_FRAG) w[13:0] = 14'($urandom_range(16383, 1));
      fb[20] = w[15:8];
      fb[21] = w[7:0];
      n = PROTO_UDP;
      if (kind == FR_PROTO) n = n ^ $urandom_range(255, 1);
      fb[23] = n[7:0];
      // end header failures early: after the protocol byte, the UDP length or the sync bytes
      if (kind inside {FR_ETHERTYPE, FR_VERSION, FR_FRAG, FR_PROTO, FR_MULTI}) len = 24;
      else if (kind inside {FR_PORT, FR_SIZE}) len = udp_at + 6;
      else if (kind == FR_SYNC) len = udp_at + 14;
      if (kind == FR_TRUNC) len = $urandom_range(full - 1, 1);
    end
    note.fixed = fixed;
    note.want.reason = reason;
    note.want.mac = (reason == RSN_FORWARD) ? mac : '0;
    note_q.push_back(note);
    for (k = 0; k < len; k++) begin
      it.data = fb[k];
      it.last = (k == len - 1);
      byte_q.push_back(it);
    end
  endtask

  function automatic frame_row_t dir_row(input int i);
    case (i)
      0:  dir_row = '{FR_GOOD,      4'd5,  48'h0011_2233_4455, 11'd0,    1'b1, RSN_FORWARD};
      1:  dir_row = '{FR_GOOD,      4'd5,  48'hffff_ffff_ffff, 11'd0,    1'b1, RSN_FORWARD};
      2:  dir_row = '{FR_GOOD,      4'd5,  48'h0000_0000_0000, 11'd4,    1'b1, RSN_FORWARD};
      3:  dir_row = '{FR_ETHERTYPE, 4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_ETHERTYPE};
      4:  dir_row = '{FR_VERSION,   4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_VERSION};
      5:  dir_row = '{FR_FRAG,      4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_FRAGMENT};
      6:  dir_row = '{FR_PROTO,     4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_PROTOCOL};
      7:  dir_row = '{FR_PORT,      4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_PORT};
      8:  dir_row = '{FR_SIZE,      4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_SIZE};
      9:  dir_row = '{FR_SYNC,      4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_SYNC};
      10: dir_row = '{FR_COPY,      4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_COPY};
      11: dir_row = '{FR_TRUNC,     4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_TRUNC};
      12: dir_row = '{FR_MULTI,     4'd5,  48'h0a0b_0c0d_0e0f, 11'd0,    1'b1, RSN_ETHERTYPE};
      13: dir_row = '{FR_NOISE,     4'd0,  48'h0,              11'd1,    1'b1, RSN_TRUNC};
      14: dir_row = '{FR_GOOD,      4'd15, 48'h1234_5678_9abc, 11'd0,    1'b0, RSN_FORWARD};
      15: dir_row = '{FR_GOOD,      4'd2,  48'h1234_5678_9abc, 11'd0,    1'b0, RSN_FORWARD};
      16: dir_row = '{FR_GOOD,      4'd0,  48'h1234_5678_9abc, 11'd0,    1'b0, RSN_FORWARD};
      17: dir_row = '{FR_GOOD,      4'd5,  48'hfedc_ba98_7654, 11'd60,   1'b0, RSN_FORWARD};
      18: dir_row = '{FR_NOISE,     4'd0,  48'h0,              11'd30,   1'b0, RSN_FORWARD};
      default: dir_row = '{FR_GOOD, 4'd4,  48'h5a5a_a5a5_0ff0, 11'd0,    1'b0, RSN_FORWARD};
    endcase
  endfunction

  task automatic random_frame();
    frame_kind_t kind;
    int r, ihl, pad;
    logic [47:0] mac;
    r = $urandom_range(99);
    if (r < 40) kind = FR_GOOD;
    else if (r < 48) kind = FR_NOISE;
    else kind = frame_kind_t'($urandom_range(FR_MULTI, FR_ETHERTYPE));
    r = $urandom_range(19);
    if (r < 15) ihl = 5;
    else if (r < 18) ihl = $urandom_range(15, 6);
    else ihl = $urandom_range(4);
    r = $urandom_range(59);
    if (r == 0) pad = $urandom_range(120, 60);
    else if (r < 15) pad = $urandom_range(40, 1);
    else pad = 0;
    if (kind == FR_NOISE) pad = $urandom_range(60, 1);
    mac = 48'({$urandom, $urandom});
    queue_frame(kind, ihl, mac, pad, 1'b0, RSN_FORWARD);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_tvalid || note_q.size() != 0 || verdict_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_wake_port(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    wake_port = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    frame_row_t row;
    int ph, f, i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      queue_frame(row.kind, int'(row.ihl), row.mac, int'(row.pad), row.fixed, row.reason);
    end
    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: set_wake_port(16'hffff);
        1: set_wake_port(16'h0000);
        default: set_wake_port(16'($urandom_range(65535)));
      endcase
      for (f = 0; f < 2; f++) begin
        while (byte_q.size() != 0) @(negedge clk);
        if (ph == 0 || $urandom_range(4) == 0) begin
          gap_pct = 0;
          stall_pct = 0;
        end else if (ph == 1) begin
          gap_pct = 56;
          stall_pct = 0;
        end else if (ph == 2) begin
          gap_pct = 0;
          stall_pct = 56;
        end else begin
          gap_pct = 38;
          stall_pct = 38;
        end
        random_frame();
      end
    end
    wait_idle();
    if (fails == 0) begin
      $display("wol_magic_packet_detector_unit_tb: clean");
    end else begin
      $display("wol_magic_packet_detector_unit_tb: errors");
    end
    $finish;
  end

endmodule
